@@ rtl/core/mee_pkg.sv @@
package mee_pkg;

	localparam int CHAR_W    = 8;
	localparam int DUR_W     = 11;
	localparam int DOT_W     = 8;
	localparam int WPM_W     = 6;
	localparam int CORR_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;
	localparam int PAT_W     = 7;
	localparam int LEN_W     = 3;
	localparam int CNT_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_WPM  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORR = 1'd1;

	localparam logic [WPM_W-1:0] WPM_MIN   = 6'd5;
	localparam logic [WPM_W-1:0] WPM_MAX   = 6'd60;
	localparam logic [DOT_W-1:0] DOT_RESET = 8'd60;

	// pattern is right-aligned in sending order, dash = 1
	typedef struct packed {
		logic             known;
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] pat;
	} code_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
	endfunction

	function automatic logic [WPM_W-1:0] clamp_wpm(input logic [WPM_W-1:0] w);
		logic [WPM_W-1:0] r;
		r = w;
		if (w < WPM_MIN) r = WPM_MIN;
		if (w > WPM_MAX) r = WPM_MAX;
		return r;
	endfunction

	// 1200 / wpm for wpm in 5..60
	function automatic logic [DOT_W-1:0] dot_from_wpm(input logic [WPM_W-1:0] w);
		logic [DOT_W-1:0] d;
		unique case (w)
			6'd5:  d = 8'd240;
			6'd6:  d = 8'd200;
			6'd7:  d = 8'd171;
			6'd8:  d = 8'd150;
			6'd9:  d = 8'd133;
			6'd10: d = 8'd120;
			6'd11: d = 8'd109;
			6'd12: d = 8'd100;
			6'd13: d = 8'd92;
			6'd14: d = 8'd85;
			6'd15: d = 8'd80;
			6'd16: d = 8'd75;
			6'd17: d = 8'd70;
			6'd18: d = 8'd66;
			6'd19: d = 8'd63;
			6'd20: d = 8'd60;
			6'd21: d = 8'd57;
			6'd22: d = 8'd54;
			6'd23: d = 8'd52;
			6'd24: d = 8'd50;
			6'd25: d = 8'd48;
			6'd26: d = 8'd46;
			6'd27: d = 8'd44;
			6'd28: d = 8'd42;
			6'd29: d = 8'd41;
			6'd30: d = 8'd40;
			6'd31: d = 8'd38;
			6'd32: d = 8'd37;
			6'd33: d = 8'd36;
			6'd34: d = 8'd35;
			6'd35: d = 8'd34;
			6'd36: d = 8'd33;
			6'd37: d = 8'd32;
			6'd38: d = 8'd31;
			6'd39: d = 8'd30;
			6'd40: d = 8'd30;
			6'd41: d = 8'd29;
			6'd42: d = 8'd28;
			6'd43: d = 8'd27;
			6'd44: d = 8'd27;
			6'd45: d = 8'd26;
			6'd46: d = 8'd26;
			6'd47: d = 8'd25;
			6'd48: d = 8'd25;
			6'd49: d = 8'd24;
			6'd50: d = 8'd24;
			6'd51: d = 8'd23;
			6'd52: d = 8'd23;
			6'd53: d = 8'd22;
			6'd54: d = 8'd22;
			6'd55: d = 8'd21;
			6'd56: d = 8'd21;
			6'd57: d = 8'd21;
			default: d = 8'd20;
		endcase
		return d;
	endfunction

	function automatic code_t lookup(input logic [CHAR_W-1:0] c_in);
		logic [CHAR_W-1:0] c;
		code_t r;
		c = c_in;
		if (c_in >= 8'h61 && c_in <= 8'h7A) c = c_in - 8'd32;
		unique case (c)
			8'h41: r = '{1'b1, 3'd2, 7'b01};
			8'h42: r = '{1'b1, 3'd4, 7'b1000};
			8'h43: r = '{1'b1, 3'd4, 7'b1010};
			8'h44: r = '{1'b1, 3'd3, 7'b100};
			8'h45: r = '{1'b1, 3'd1, 7'b0};
			8'h46: r = '{1'b1, 3'd4, 7'b0010};
			8'h47: r = '{1'b1, 3'd3, 7'b110};
			8'h48: r = '{1'b1, 3'd4, 7'b0000};
			8'h49: r = '{1'b1, 3'd2, 7'b00};
			8'h4A: r = '{1'b1, 3'd4, 7'b0111};
			8'h4B: r = '{1'b1, 3'd3, 7'b101};
			8'h4C: r = '{1'b1, 3'd4, 7'b0100};
			8'h4D: r = '{1'b1, 3'd2, 7'b11};
			8'h4E: r = '{1'b1, 3'd2, 7'b10};
			8'h4F: r = '{1'b1, 3'd3, 7'b111};
			8'h50: r = '{1'b1, 3'd4, 7'b0110};
			8'h51: r = '{1'b1, 3'd4, 7'b1101};
			8'h52: r = '{1'b1, 3'd3, 7'b010};
			8'h53: r = '{1'b1, 3'd3, 7'b000};
			8'h54: r = '{1'b1, 3'd1, 7'b1};
			8'h55: r = '{1'b1, 3'd3, 7'b001};
			8'h56: r = '{1'b1, 3'd4, 7'b0001};
			8'h57: r = '{1'b1, 3'd3, 7'b011};
			8'h58: r = '{1'b1, 3'd4, 7'b1001};
			8'h59: r = '{1'b1, 3'd4, 7'b1011};
			8'h5A: r = '{1'b1, 3'd4, 7'b1100};
			8'h30: r = '{1'b1, 3'd5, 7'b11111};
			8'h31: r = '{1'b1, 3'd5, 7'b01111};
			8'h32: r = '{1'b1, 3'd5, 7'b00111};
			8'h33: r = '{1'b1, 3'd5, 7'b00011};
			8'h34: r = '{1'b1, 3'd5, 7'b00001};
			8'h35: r = '{1'b1, 3'd5, 7'b00000};
			8'h36: r = '{1'b1, 3'd5, 7'b10000};
			8'h37: r = '{1'b1, 3'd5, 7'b11000};
			8'h38: r = '{1'b1, 3'd5, 7'b11100};
			8'h39: r = '{1'b1, 3'd5, 7'b11110};
			8'h2E: r = '{1'b1, 3'd6, 7'b010101};
			8'h2C: r = '{1'b1, 3'd6, 7'b110011};
			8'h3F: r = '{1'b1, 3'd6, 7'b001100};
			8'h27: r = '{1'b1, 3'd6, 7'b011110};
			8'h21: r = '{1'b1, 3'd6, 7'b101011};
			8'h2F: r = '{1'b1, 3'd5, 7'b10010};
			8'h28: r = '{1'b1, 3'd5, 7'b10110};
			8'h29: r = '{1'b1, 3'd6, 7'b101101};
			8'h26: r = '{1'b1, 3'd5, 7'b01000};
			8'h3A: r = '{1'b1, 3'd6, 7'b111000};
			8'h3B: r = '{1'b1, 3'd6, 7'b101010};
			8'h3D: r = '{1'b1, 3'd5, 7'b10001};
			8'h2B: r = '{1'b1, 3'd5, 7'b01010};
			8'h2D: r = '{1'b1, 3'd6, 7'b100001};
			8'h5F: r = '{1'b1, 3'd6, 7'b001101};
			8'h22: r = '{1'b1, 3'd6, 7'b010010};
			8'h24: r = '{1'b1, 3'd7, 7'b0001001};
			8'h40: r = '{1'b1, 3'd6, 7'b011010};
			default: r = '{1'b0, 3'd0, 7'b0};
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/mee_if.sv @@
interface mee_in_if;
	logic                        valid;
	logic                        ready;
	logic [mee_pkg::CHAR_W-1:0]  character;
	logic                        text_start;
	logic                        player_busy;

	modport source (output valid, output character, output text_start, output player_busy,
		input ready);
	modport sink (input valid, input character, input text_start, input player_busy,
		output ready);
endinterface

interface mee_out_if;
	logic                       valid;
	logic                       ready;
	logic                       key_down;
	logic [mee_pkg::DUR_W-1:0]  duration_ms;
	logic                       last;

	modport source (output valid, output key_down, output duration_ms, output last,
		input ready);
	modport sink (input valid, input key_down, input duration_ms, input last,
		output ready);
endinterface

@@ rtl/core/morse_element_encoder_unit.sv @@
// Morse element encoder: text characters in, timed key elements out.
// char_in carries one Latin-1 character per transfer with text_start and
// player_busy; elem_out carries one element per transfer (key_down,
// duration_ms, last), last set on the final element of a character.
// Speed and mark correction are written through cfg_we/cfg_index/cfg_wdata
// by the user only while the block is idle; the block does not enforce this.
// A speed write is clamped to 5..60 wpm and the dot length is looked up at once.
// After a character is taken the block produces its elements one per cycle
// while the receiver takes them, through a single shared duration unit (dot
// or mark base times 1, 3 or 7) under a small sequencer, and char_in.ready
// is low until the last element of the character has been produced.
// Whitespace and unknown characters give no mark, only any gap that is due.
// The first element enters the output register from ST_EMIT when it is free.
// When the receiver stalls, the element waits in the output register and
// the sequencer holds until it is taken.
// Reset sets 20 wpm (60 ms dot), zero correction and clears the word state.
module morse_element_encoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mee_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mee_pkg::CFG_DAT_W-1:0]      cfg_wdata,
	mee_in_if.sink                             char_in,
	mee_out_if.source                          elem_out
);
	import mee_pkg::*;

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;
	typedef enum logic [2:0] {K_BGAP, K_WGAP, K_CGAP, K_IGAP, K_MARK} kind_t;
	typedef enum logic [1:0] {F_X1, F_X3, F_X7} factor_t;

	state_t            state_q;
	logic [DOT_W-1:0]  dot_q;
	logic [CORR_W-1:0] corr_q;
	logic              word_open_q;
	logic              pos_nz_q;
	logic              word_seen_q;
	logic              first_pend_q;
	logic              bgap_q;
	logic              wgap_q;
	logic              cgap_q;
	logic              gap_next_q;
	logic [PAT_W-1:0]  pat_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              key_down_q;
	logic [DUR_W-1:0]  dur_q;
	logic              last_q;

	logic              in_xfer;
	logic              out_free;
	logic [DOT_W-1:0]  keyed;

	// accept-time evaluation
	logic              wo_e, pnz_e, ws_e, fp_e;
	logic              blank;
	code_t             code;
	logic              bgap_n, wgap_n, cgap_n;
	logic              wo_n, pnz_n, ws_n, fp_n;
	logic [CNT_W-1:0]  cnt_n;

	// element selection and shared duration unit
	kind_t             kind;
	factor_t           factor;
	logic [DOT_W-1:0]  base;
	logic [DUR_W-1:0]  base_x;
	logic [DUR_W-1:0]  dur;

	assign in_xfer  = char_in.valid && char_in.ready;
	assign out_free = !out_valid_q || elem_out.ready;
	assign keyed    = (dot_q > corr_q) ? dot_q - corr_q : 8'd1;

	assign char_in.ready        = (state_q == ST_IDLE);
	assign elem_out.valid       = out_valid_q;
	assign elem_out.key_down    = key_down_q;
	assign elem_out.duration_ms = dur_q;
	assign elem_out.last        = last_q;

	always_comb begin
		wo_e   = char_in.text_start ? 1'b0 : word_open_q;
		pnz_e  = char_in.text_start ? 1'b0 : pos_nz_q;
		ws_e   = char_in.text_start ? 1'b0 : word_seen_q;
		fp_e   = char_in.text_start ? 1'b1 : first_pend_q;
		blank  = is_blank(char_in.character);
		code   = lookup(char_in.character);
		bgap_n = char_in.text_start && char_in.player_busy;
		wgap_n = 1'b0;
		cgap_n = 1'b0;
		wo_n   = wo_e;
		pnz_n  = pnz_e;
		ws_n   = ws_e;
		fp_n   = fp_e;
		if (blank) begin
			if (wo_e) fp_n = 1'b0;
			wo_n = 1'b0;
			code = '{1'b0, 3'd0, 7'b0};
		end else begin
			if (!wo_e) begin
				wgap_n = ws_e;
				ws_n   = 1'b1;
				pnz_e  = 1'b0;
			end
			wo_n = 1'b1;
			if (code.known) begin
				cgap_n = !fp_e && pnz_e;
				fp_n   = 1'b0;
			end
			pnz_n = 1'b1;
		end
		cnt_n = {3'b0, bgap_n} + {3'b0, wgap_n} + {3'b0, cgap_n}
			+ (code.known ? {code.len, 1'b0} - 4'd1 : 4'd0);
	end

	always_comb begin
		if (bgap_q) kind = K_BGAP;
		else if (wgap_q) kind = K_WGAP;
		else if (cgap_q) kind = K_CGAP;
		else if (gap_next_q) kind = K_IGAP;
		else kind = K_MARK;

		unique case (kind)
			K_BGAP, K_WGAP: begin
				factor = F_X7;
				base   = dot_q;
			end
			K_CGAP: begin
				factor = F_X3;
				base   = dot_q;
			end
			K_IGAP: begin
				factor = F_X1;
				base   = dot_q;
			end
			default: begin
				factor = pat_q[PAT_W-1] ? F_X3 : F_X1;
				base   = keyed;
			end
		endcase

		base_x = {3'b0, base};
		unique case (factor)
			F_X3:    dur = {base_x[DUR_W-2:0], 1'b0} + base_x;
			F_X7:    dur = {base_x[DUR_W-4:0], 3'b0} - base_x;
			default: dur = base_x;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dot_q        <= DOT_RESET;
			corr_q       <= '0;
			word_open_q  <= 1'b0;
			pos_nz_q     <= 1'b0;
			word_seen_q  <= 1'b0;
			first_pend_q <= 1'b1;
			bgap_q       <= 1'b0;
			wgap_q       <= 1'b0;
			cgap_q       <= 1'b0;
			gap_next_q   <= 1'b0;
			pat_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			key_down_q   <= 1'b0;
			dur_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WPM:  dot_q  <= dot_from_wpm(clamp_wpm(cfg_wdata[WPM_W-1:0]));
					REG_CORR: corr_q <= cfg_wdata[CORR_W-1:0];
					default:  ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (elem_out.ready) out_valid_q <= 1'b0;
					if (in_xfer) begin
						word_open_q  <= wo_n;
						pos_nz_q     <= pnz_n;
						word_seen_q  <= ws_n;
						first_pend_q <= fp_n;
						bgap_q       <= bgap_n;
						wgap_q       <= wgap_n;
						cgap_q       <= cgap_n;
						gap_next_q   <= 1'b0;
						pat_q        <= code.pat << (3'd7 - code.len);
						cnt_q        <= cnt_n;
						if (cnt_n != '0) state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						key_down_q  <= (kind == K_MARK);
						dur_q       <= dur;
						last_q      <= (cnt_q == 4'd1);
						cnt_q       <= cnt_q - 4'd1;
						unique case (kind)
							K_BGAP: bgap_q <= 1'b0;
							K_WGAP: wgap_q <= 1'b0;
							K_CGAP: cgap_q <= 1'b0;
							K_IGAP: gap_next_q <= 1'b0;
							default: begin
								pat_q      <= {pat_q[PAT_W-2:0], 1'b0};
								gap_next_q <= 1'b1;
							end
						endcase
						if (cnt_q == 4'd1) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
